/* hw/rtl/audio_chunk_splice_aligner_defines.svh */
// ============================================================================
// Audio chunk splice aligner: assertion macros
// Implication checks on the block's clock and reset. They compile away in
// synthesis builds.
// ============================================================================
`ifndef AUDIO_CHUNK_SPLICE_ALIGNER_DEFINES_SVH
`define AUDIO_CHUNK_SPLICE_ALIGNER_DEFINES_SVH

`ifndef SYNTH
`define ACSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("acsa assertion failed");
`define ACSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("acsa assertion failed");
`else
`define ACSA_ASSERT_IMPL(lbl, ante, cons)
`define ACSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/acsa_pkg.sv */
// ============================================================================
// Audio chunk splice aligner: package
// Sample and offset widths, input mode codes and the search pipeline tag.
// ============================================================================
package acsa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int OFFSET_W = 7;

    localparam logic MODE_TAIL = 1'b0;
    localparam logic MODE_CAND = 1'b1;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } acsa_tag_t;

endpackage

/* hw/rtl/acsa_sample_store.sv */
// ============================================================================
// Audio chunk splice aligner: sample store
// One write port, one read port, read data registered.
// ============================================================================
module acsa_sample_store
    import acsa_pkg::*;
#(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/acsa_sad_unit.sv */
// ============================================================================
// Audio chunk splice aligner: SAD unit
// Pipelined absolute difference, per-offset accumulation and first strict
// minimum tracking over the streamed tail and candidate reads.
// ============================================================================
module acsa_sad_unit
    import acsa_pkg::*;
#(
    parameter int CAND_AW = 7,
    parameter int SUM_W   = 21
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  acsa_tag_t           tag_in,
    input  logic [CAND_AW-1:0]  off_in,
    input  logic [SAMPLE_W-1:0] tail_rdata,
    input  logic [SAMPLE_W-1:0] cand_rdata,
    output logic                busy,
    output logic [CAND_AW-1:0]  best_start
);

    acsa_tag_t           tag_a_reg, tag_b_reg, tag_c_reg;
    logic [CAND_AW-1:0]  off_a_reg, off_b_reg, off_c_reg;
    logic [SAMPLE_W-1:0] abs_reg, abs_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    best_sum_reg, best_sum_next;
    logic [CAND_AW-1:0]  best_start_reg, best_start_next;
    logic [SAMPLE_W:0]   diff, diff_neg;

    always_comb begin
        diff     = {tail_rdata[SAMPLE_W-1], tail_rdata}
                 - {cand_rdata[SAMPLE_W-1], cand_rdata};
        diff_neg = '0 - diff;
        abs_next = diff[SAMPLE_W] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];

        acc_next = (tag_b_reg.first ? '0 : acc_reg) + SUM_W'(abs_reg);

        best_sum_next   = best_sum_reg;
        best_start_next = best_start_reg;
        if (start) begin
            best_sum_next   = '1;
            best_start_next = '0;
        end else if (tag_c_reg.vld && tag_c_reg.last && (acc_reg < best_sum_reg)) begin
            best_sum_next   = acc_reg;
            best_start_next = off_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg      <= '0;
            tag_b_reg      <= '0;
            tag_c_reg      <= '0;
            best_sum_reg   <= '1;
            best_start_reg <= '0;
        end else begin
            tag_a_reg      <= tag_in;
            tag_b_reg      <= tag_a_reg;
            tag_c_reg      <= tag_b_reg;
            best_sum_reg   <= best_sum_next;
            best_start_reg <= best_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_a_reg <= off_in;
        off_b_reg <= off_a_reg;
        off_c_reg <= off_b_reg;
        abs_reg   <= abs_next;
        if (tag_b_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    assign busy       = tag_a_reg.vld | tag_b_reg.vld | tag_c_reg.vld;
    assign best_start = best_start_reg;

endmodule

/* hw/rtl/audio_chunk_splice_aligner.sv */
// ============================================================================
// Audio chunk splice aligner
// Load the newest COMPARE_LEN tail samples (mode 0), then the candidate
// samples of the next chunk (mode 1). The word that completes the candidate
// set starts a search: every offset reads one tail and one candidate sample
// per cycle from the two single-read-port stores, then the SAD pipeline
// drains. COMPARE_LEN blended words follow, each read in ST_EMIT_RD and
// loaded in ST_EMIT_LD once the output register is free. s_ready is low
// from the search start until the last blended word is loaded into the
// output register. Candidates sent before the tail is full are dropped.
// ============================================================================
`include "audio_chunk_splice_aligner_defines.svh"

module audio_chunk_splice_aligner
    import acsa_pkg::*;
#(
    parameter int COMPARE_LEN = 24,
    parameter int SEARCH_HALF = 44,
    parameter int OFFSET_STEP = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_blended_sample,
    output logic [OFFSET_W-1:0]        m_best_offset,
    output logic                       m_last
);

    localparam int NUM_OFFSETS = (2 * SEARCH_HALF + OFFSET_STEP - 1) / OFFSET_STEP;
    localparam int LAST_OFFSET = (NUM_OFFSETS - 1) * OFFSET_STEP;
    localparam int CAND_LEN    = LAST_OFFSET + COMPARE_LEN;
    localparam int TAIL_AW     = $clog2(COMPARE_LEN);
    localparam int CAND_AW     = $clog2(CAND_LEN);
    localparam int TCNT_W      = $clog2(COMPARE_LEN + 1);
    localparam int SUM_W       = $clog2(COMPARE_LEN) + SAMPLE_W;
    localparam int EXT_W       = CAND_AW + OFFSET_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [TCNT_W-1:0]   tail_count_reg, tail_count_next;
    logic [CAND_AW-1:0]  cand_count_reg, cand_count_next;
    logic [TAIL_AW-1:0]  tail_wptr_reg, tail_wptr_next;
    logic [TAIL_AW-1:0]  k_reg, k_next;
    logic [CAND_AW-1:0]  off_reg, off_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_blended_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic                m_last_reg;

    logic                s_accept;
    logic                tail_we, cand_we;
    logic [TAIL_AW:0]    tail_sum;
    logic [TAIL_AW-1:0]  tail_raddr;
    logic [CAND_AW-1:0]  cand_raddr;
    logic [SAMPLE_W-1:0] tail_rdata, cand_rdata;
    logic                sad_start, sad_busy;
    acsa_tag_t           sad_tag;
    logic [CAND_AW-1:0]  best_start;
    logic [EXT_W-1:0]    best_ext;
    logic [SAMPLE_W:0]   blend_sum, blend_adj;
    logic                k_is_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign k_is_last = (k_reg == TAIL_AW'(COMPARE_LEN - 1));

    // map logical tail index to the circular store (oldest entry at wptr)
    always_comb begin
        tail_sum = {1'b0, tail_wptr_reg} + {1'b0, k_reg};
        if (tail_sum >= (TAIL_AW + 1)'(COMPARE_LEN)) begin
            tail_sum = tail_sum - (TAIL_AW + 1)'(COMPARE_LEN);
        end
        tail_raddr = tail_sum[TAIL_AW-1:0];
        cand_raddr = ((state_reg == ST_SEARCH) ? off_reg : best_start) + CAND_AW'(k_reg);
    end

    assign tail_we = s_accept && (s_mode == MODE_TAIL);
    assign cand_we = s_accept && (s_mode == MODE_CAND)
                   && (tail_count_reg == TCNT_W'(COMPARE_LEN));

    always_comb begin
        blend_sum = {tail_rdata[SAMPLE_W-1], tail_rdata}
                  + {cand_rdata[SAMPLE_W-1], cand_rdata};
        blend_adj = blend_sum + {{SAMPLE_W{1'b0}}, blend_sum[SAMPLE_W]};
        best_ext  = EXT_W'(best_start);
    end

    always_comb begin
        state_next      = state_reg;
        tail_count_next = tail_count_reg;
        cand_count_next = cand_count_reg;
        tail_wptr_next  = tail_wptr_reg;
        k_next          = k_reg;
        off_next        = off_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        sad_start       = 1'b0;
        sad_tag         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (tail_we) begin
                    tail_wptr_next = (tail_wptr_reg == TAIL_AW'(COMPARE_LEN - 1))
                                   ? '0 : tail_wptr_reg + 1'b1;
                    if (tail_count_reg != TCNT_W'(COMPARE_LEN)) begin
                        tail_count_next = tail_count_reg + 1'b1;
                    end
                end
                if (cand_we) begin
                    if (cand_count_reg == CAND_AW'(CAND_LEN - 1)) begin
                        cand_count_next = '0;
                        tail_count_next = '0;
                        k_next          = '0;
                        off_next        = '0;
                        sad_start       = 1'b1;
                        state_next      = ST_SEARCH;
                    end else begin
                        cand_count_next = cand_count_reg + 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                sad_tag.vld   = 1'b1;
                sad_tag.first = (k_reg == '0);
                sad_tag.last  = k_is_last;
                if (k_is_last) begin
                    k_next = '0;
                    if (off_reg == CAND_AW'(LAST_OFFSET)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        off_next = off_reg + CAND_AW'(OFFSET_STEP);
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sad_busy) begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                m_valid_next = 1'b1;
                if (k_is_last) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tail_count_reg <= '0;
            cand_count_reg <= '0;
            tail_wptr_reg  <= '0;
            k_reg          <= '0;
            off_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tail_count_reg <= tail_count_next;
            cand_count_reg <= cand_count_next;
            tail_wptr_reg  <= tail_wptr_next;
            k_reg          <= k_next;
            off_reg        <= off_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT_LD) begin
            m_blended_reg <= blend_adj[SAMPLE_W:1];
            m_offset_reg  <= best_ext[OFFSET_W-1:0];
            m_last_reg    <= k_is_last;
        end
    end

    acsa_sample_store #(
        .DEPTH (COMPARE_LEN),
        .AW    (TAIL_AW)
    ) u_tail_store (
        .aclk  (aclk),
        .we    (tail_we),
        .waddr (tail_wptr_reg),
        .wdata ($unsigned(s_sample)),
        .raddr (tail_raddr),
        .rdata (tail_rdata)
    );

    acsa_sample_store #(
        .DEPTH (CAND_LEN),
        .AW    (CAND_AW)
    ) u_cand_store (
        .aclk  (aclk),
        .we    (cand_we),
        .waddr (cand_count_reg),
        .wdata ($unsigned(s_sample)),
        .raddr (cand_raddr),
        .rdata (cand_rdata)
    );

    acsa_sad_unit #(
        .CAND_AW (CAND_AW),
        .SUM_W   (SUM_W)
    ) u_sad_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sad_start),
        .tag_in     (sad_tag),
        .off_in     (off_reg),
        .tail_rdata (tail_rdata),
        .cand_rdata (cand_rdata),
        .busy       (sad_busy),
        .best_start (best_start)
    );

    assign m_valid          = m_valid_reg;
    assign m_blended_sample = $signed(m_blended_reg);
    assign m_best_offset    = m_offset_reg;
    assign m_last           = m_last_reg;

    `ACSA_ASSERT_IMPL(a_out_from_emit, $rose(m_valid_reg), $past(state_reg) == ST_EMIT_LD)
    `ACSA_ASSERT_IMPL(a_search_counts_clear, state_reg == ST_SEARCH, (tail_count_reg == '0) && (cand_count_reg == '0))
    `ACSA_ASSERT_IMPL(a_load_slot_free, state_reg == ST_EMIT_LD, !m_valid_reg)
    `ACSA_ASSERT_NEXT(a_drain_to_emit, (state_reg == ST_DRAIN) && !sad_busy, state_reg == ST_EMIT_RD)

endmodule

/* tb/audio_chunk_splice_aligner_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Audio chunk splice aligner testbench
// Streams tail and candidate words into the aligner and predicts every blended
// word with an in-bench search over all offsets. Directed splices cover
// sample extremes, ignored early candidates and ties between offsets. A final
// splice with a planted match takes tail words during the candidate load
// under one long output hold, with no idling on either side.
// ============================================================================
module audio_chunk_splice_aligner_tb;
    import acsa_pkg::*;

    localparam int SPLICE_LEN  = 24;
    localparam int SEARCH_SPAN = 44;
    localparam int OFF_STEP    = 4;
    localparam int NUM_OFFSETS = (2 * SEARCH_SPAN + OFF_STEP - 1) / OFF_STEP;
    localparam int LAST_OFF    = (NUM_OFFSETS - 1) * OFF_STEP;
    localparam int CAND_LEN    = LAST_OFF + SPLICE_LEN;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] blended;
        logic [OFFSET_W-1:0]        offset;
        logic                       last;
    } blend_word_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_mode;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_blended_sample;
    logic [OFFSET_W-1:0]        m_best_offset;
    logic                       m_last;

    logic signed [SAMPLE_W-1:0] tail_shift [SPLICE_LEN];
    logic signed [SAMPLE_W-1:0] cand_buf [CAND_LEN];
    int                         tail_fill;
    int                         cand_fill;

    blend_word_t pending_blends [$];
    int          mismatch_count;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_hold_len;

    audio_chunk_splice_aligner u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_blended_sample (m_blended_sample),
        .m_best_offset    (m_best_offset),
        .m_last           (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void predict_splice();
        int          sum;
        int          best_sum;
        int          best_off;
        int          diff;
        int          avg;
        blend_word_t w;
        best_sum = 32'h7fff_ffff;
        best_off = 0;
        for (int off = 0; off <= LAST_OFF; off += OFF_STEP) begin
            sum = 0;
            for (int k = 0; k < SPLICE_LEN; k++) begin
                diff = int'(tail_shift[k]) - int'(cand_buf[off + k]);
                sum += (diff < 0) ? -diff : diff;
            end
            if (sum < best_sum) begin
                best_sum = sum;
                best_off = off;
            end
        end
        for (int k = 0; k < SPLICE_LEN; k++) begin
            avg = (int'(tail_shift[k]) + int'(cand_buf[best_off + k])) / 2;
            w.blended = avg[SAMPLE_W-1:0];
            w.offset  = best_off[OFFSET_W-1:0];
            w.last    = (k == SPLICE_LEN - 1);
            pending_blends = {pending_blends, w};
        end
        tail_fill = 0;
        cand_fill = 0;
    endfunction

    // model one accepted word: tail words shift in; a candidate is dropped while the tail is not full
    function automatic void absorb_word(input logic mode, input logic signed [SAMPLE_W-1:0] smp);
        if (mode == MODE_TAIL) begin
            for (int k = 0; k < SPLICE_LEN - 1; k++)
                tail_shift[k] = tail_shift[k + 1];
            tail_shift[SPLICE_LEN-1] = smp;
            if (tail_fill < SPLICE_LEN)
                tail_fill++;
            return;
        end
        if (tail_fill < SPLICE_LEN)
            return;
        if (cand_fill >= CAND_LEN)
            cand_fill = 0;
        cand_buf[cand_fill] = smp;
        cand_fill++;
        if (cand_fill == CAND_LEN)
            predict_splice();
    endfunction

    task automatic send_word(input logic mode, input logic [SAMPLE_W-1:0] smp);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        absorb_word(mode, smp);
        @(negedge aclk);
    endtask

    task automatic wait_for_blends();
        s_valid <= 1'b0;
        while (pending_blends.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_candidate(int idx, int style, int plant,
                                                           int noise_amp);
        int v;
        if (plant >= 0 && idx >= plant && idx < plant + SPLICE_LEN) begin
            v = int'(tail_shift[idx - plant]) + int'($urandom_range(0, 2 * noise_amp))
                - noise_amp;
        end else begin
            case (style)
                0: v = $signed(16'($urandom));
                1: v = int'($urandom_range(0, 600)) - 300;
                2: v = $urandom_range(0, 1) ? 32767 : -32768;
                default: v = int'(tail_shift[idx % SPLICE_LEN]);
            endcase
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic test_early_candidates();
        send_word(MODE_CAND, 16'h7fff);
        send_word(MODE_CAND, 16'h8000);
        repeat (10) send_word(MODE_TAIL, 16'($urandom));
        send_word(MODE_CAND, 16'h0000);
    endtask

    task automatic test_blend_extremes();
        int tail_pat [8] = '{-32768, 32767, -1, 0, 1, -32767, 32766, -3};
        int cand_pat [8] = '{-32768, 32767, 0, -1, -2, 32767, -32768, 2};
        for (int k = 0; k < SPLICE_LEN + 2; k++)
            send_word(MODE_TAIL, 16'(tail_pat[k % 8]));
        for (int i = 0; i < CAND_LEN; i++)
            send_word(MODE_CAND, 16'(cand_pat[(i + i / 8) % 8]));
    endtask

    task automatic test_offset_ties();
        for (int k = 0; k < SPLICE_LEN; k++)
            send_word(MODE_TAIL, 16'(k * 37 - 400));
        for (int i = 0; i < CAND_LEN; i++) begin
            if (i >= 36 && i < 36 + SPLICE_LEN)
                send_word(MODE_CAND, tail_shift[i - 36]);
            else if (i >= LAST_OFF)
                send_word(MODE_CAND, tail_shift[i - LAST_OFF]);
            else
                send_word(MODE_CAND, 16'(20000));
        end
    endtask

    task automatic test_tail_during_load();
        int style;
        int plant;
        int noise_amp;
        repeat (SPLICE_LEN) send_word(MODE_TAIL, 16'($urandom));
        style     = $urandom_range(0, 3);
        plant     = $urandom_range(0, NUM_OFFSETS - 1) * OFF_STEP;
        noise_amp = $urandom_range(0, 400);
        for (int i = 0; i < CAND_LEN; i++) begin
            if (i == 40)
                repeat (3) send_word(MODE_TAIL, 16'($urandom));
            send_word(MODE_CAND, pick_candidate(i, style, plant, noise_amp));
        end
    endtask

    task automatic test_output_hold();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_len = 2500;
        test_tail_during_load();
        repeat (10) send_word(MODE_TAIL, 16'($urandom));
        wait_for_blends();
    endtask

    initial begin
        int rx_stall;
        rx_stall = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                rx_stall    = rx_hold_len;
                rx_hold_len = 0;
            end else if (rx_stall == 0 && rx_idle_on && $urandom_range(0, 9) == 0) begin
                rx_stall = $urandom_range(1, 17);
            end
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        blend_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blends.size() == 0) begin
                $error("unexpected blended word %0d", $signed(m_blended_sample));
                mismatch_count++;
            end else begin
                w = pending_blends.pop_front();
                if (m_blended_sample !== w.blended) begin
                    $error("blended_sample expected %0d actual %0d",
                           $signed(w.blended), $signed(m_blended_sample));
                    mismatch_count++;
                end
                if (m_best_offset !== w.offset) begin
                    $error("best_offset expected %0d actual %0d", w.offset, m_best_offset);
                    mismatch_count++;
                end
                if (m_last !== w.last) begin
                    $error("last expected %0d actual %0d", w.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("audio_chunk_splice_aligner verification failed");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = MODE_TAIL;
        s_sample        = '0;
        tail_fill       = 0;
        cand_fill       = 0;
        mismatch_count  = 0;
        rx_hold_len     = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_early_candidates();
        test_blend_extremes();
        test_offset_ties();
        test_output_hold();

        wait_for_blends();
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0)
            $display("audio_chunk_splice_aligner verification clean");
        else
            $display("audio_chunk_splice_aligner verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/acsa_pkg.sv
hw/rtl/acsa_sample_store.sv
hw/rtl/acsa_sad_unit.sv
hw/rtl/audio_chunk_splice_aligner.sv
tb/audio_chunk_splice_aligner_tb.sv
